### rtl/core/md5_pkg.sv
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } dig_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam int BlockWords = 16;
  localparam int WordBits   = 32;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] r;
    case (sel)
      4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
      4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
      4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] w;
    case (i[5:4])
      2'd0:    w = i[3:0];
      2'd1:    w = 4'(4'd5 * i[3:0] + 4'd1);
      2'd2:    w = 4'(4'd3 * i[3:0] + 4'd5);
      default: w = 4'(4'd7 * i[3:0]);
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] t;
    t = {v, v} << r;
    return t[63:32];
  endfunction

endpackage

### rtl/core/md5_digest_engine.sv
// Bytes are taken one per cycle, but only while the engine is idle and msg_ready is high.
// The 64th byte of a block starts a compression (load, 64 rounds, add).
// End of message costs the padding writes plus one or two compressions, then
// four digest responses, one per cycle while the consumer is ready.
// Reset is synchronous and returns the chaining words and bit count to start values.
module md5_digest_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_ready,
  input  md5_pkg::msg_t       msg,
  output logic                dig_valid,
  input  logic                dig_ready,
  output md5_pkg::dig_t       dig
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD_FIRST, S_PAD_ZERO, S_PAD2, S_LOAD, S_ROUND, S_ADD, S_OUT
  } state_t;

  typedef enum logic [1:0] {M_CONT, M_PAD, M_PAD2, M_FINAL} mode_t;

  state_t      state;
  mode_t       mode;
  logic [63:0] bit_count;
  logic [31:0] acc;
  logic [31:0] chain [4];
  logic [31:0] ra, rb, rc, rd;
  logic [5:0]  ri;
  logic [3:0]  widx;
  logic [1:0]  idx;

  logic [5:0]  pos;
  logic [1:0]  lane;
  logic        two;
  logic        accept;
  logic [31:0] acc_ins, pad_word, len_word;
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [31:0] mix, sum, new_b;
  logic [1:0]  grp;

  assign pos    = bit_count[8:3];
  assign lane   = pos[1:0];
  assign two    = &pos[5:3];
  assign accept = msg_valid && msg_ready;
  assign msg_ready = (state == S_IDLE);
  assign grp    = ri[5:4];

  always_comb begin
    case (lane)
      2'd0:    acc_ins = {24'h0, msg.data_byte};
      2'd1:    acc_ins = {16'h0, msg.data_byte, acc[7:0]};
      2'd2:    acc_ins = {8'h0, msg.data_byte, acc[15:0]};
      default: acc_ins = {msg.data_byte, acc[23:0]};
    endcase
    case (lane)
      2'd0:    pad_word = 32'h80;
      2'd1:    pad_word = {16'h0, 8'h80, acc[7:0]};
      2'd2:    pad_word = {8'h0, 8'h80, acc[15:0]};
      default: pad_word = {8'h80, acc[23:0]};
    endcase
    if (widx == 4'd14) begin
      len_word = bit_count[31:0];
    end else if (widx == 4'd15) begin
      len_word = bit_count[63:32];
    end else begin
      len_word = '0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = widx;
    wdata = len_word;
    raddr = md5_pkg::word_sel(6'(ri + 6'd1));
    unique case (state)
      S_IDLE: begin
        we    = accept && msg.byte_present && (lane == 2'd3);
        waddr = pos[5:2];
        wdata = acc_ins;
      end
      S_PAD_FIRST: begin
        we    = 1'b1;
        waddr = pos[5:2];
        wdata = pad_word;
      end
      S_PAD_ZERO: begin
        we    = 1'b1;
        wdata = two ? '0 : len_word;
      end
      S_PAD2: we = 1'b1;
      S_LOAD: raddr = md5_pkg::word_sel('0);
      default: ;
    endcase
  end

  md5_ram #(.Width(md5_pkg::WordBits), .Depth(md5_pkg::BlockWords)) u_block (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (grp)
      2'd0:    mix = (rb & rc) | (~rb & rd);
      2'd1:    mix = (rb & rd) | (rc & ~rd);
      2'd2:    mix = rb ^ rc ^ rd;
      default: mix = rc ^ (rb | ~rd);
    endcase
    sum   = ra + mix + rdata + md5_pkg::round_const(ri);
    new_b = rb + md5_pkg::rotl(sum, md5_pkg::rot_amount({grp, ri[1:0]}));
  end

  assign dig.digest_word = chain[idx];
  assign dig.word_index  = idx;
  assign dig.last_word   = (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_CONT;
      bit_count <= '0;
      chain[0]  <= md5_pkg::INIT_A;
      chain[1]  <= md5_pkg::INIT_B;
      chain[2]  <= md5_pkg::INIT_C;
      chain[3]  <= md5_pkg::INIT_D;
      ri        <= '0;
      widx      <= '0;
      idx       <= '0;
      dig_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (msg.byte_present) begin
              acc       <= acc_ins;
              bit_count <= bit_count + 64'd8;
              if (pos == 6'd63) begin
                state <= S_LOAD;
                mode  <= msg.end_of_message ? M_PAD : M_CONT;
              end else if (msg.end_of_message) begin
                state <= S_PAD_FIRST;
              end
            end else if (msg.end_of_message) begin
              state <= S_PAD_FIRST;
            end
          end
        end
        S_PAD_FIRST: begin
          if (pos[5:2] == 4'd15) begin
            state <= S_LOAD;
            mode  <= M_PAD2;
          end else begin
            widx  <= 4'(pos[5:2] + 4'd1);
            state <= S_PAD_ZERO;
          end
        end
        S_PAD_ZERO: begin
          widx <= 4'(widx + 4'd1);
          if (widx == 4'd15) begin
            state <= S_LOAD;
            mode  <= two ? M_PAD2 : M_FINAL;
          end
        end
        S_PAD2: begin
          widx <= 4'(widx + 4'd1);
          if (widx == 4'd15) begin
            state <= S_LOAD;
            mode  <= M_FINAL;
          end
        end
        S_LOAD: begin
          ra    <= chain[0];
          rb    <= chain[1];
          rc    <= chain[2];
          rd    <= chain[3];
          ri    <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          ra <= rd;
          rb <= new_b;
          rc <= rb;
          rd <= rc;
          ri <= 6'(ri + 6'd1);
          if (ri == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd;
          unique case (mode)
            M_CONT:  state <= S_IDLE;
            M_PAD:   state <= S_PAD_FIRST;
            M_PAD2: begin
              widx  <= '0;
              state <= S_PAD2;
            end
            M_FINAL: begin
              idx       <= '0;
              dig_valid <= 1'b1;
              state     <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (dig_ready) begin
            if (idx == 2'd3) begin
              dig_valid <= 1'b0;
              bit_count <= '0;
              chain[0]  <= md5_pkg::INIT_A;
              chain[1]  <= md5_pkg::INIT_B;
              chain[2]  <= md5_pkg::INIT_C;
              chain[3]  <= md5_pkg::INIT_D;
              idx       <= '0;
              state     <= S_IDLE;
            end else begin
              idx <= 2'(idx + 2'd1);
            end
          end
        end
      endcase
    end
  end

endmodule

### rtl/core/md5_ram.sv
module md5_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/md5_checker.sv
module md5_checker (
  input logic          clk,
  input logic          rst,
  input logic          msg_valid,
  input logic          msg_ready,
  input md5_pkg::msg_t msg,
  input logic          dig_valid,
  input logic          dig_ready,
  input md5_pkg::dig_t dig
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(dig))
    else $error("Digest response changed while stalled.");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && dig_valid))
    else $error("Request accepted while a digest is pending.");

  a_last: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig.last_word == (dig.word_index == 2'd3)))
    else $error("Last flag does not match word D.");

  a_next: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && !dig.last_word |=>
      dig_valid && (dig.word_index == 2'($past(dig.word_index) + 2'd1)))
    else $error("Digest words out of order.");

endmodule

bind md5_digest_engine md5_checker u_md5_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg_valid),
  .msg_ready (msg_ready),
  .msg       (msg),
  .dig_valid (dig_valid),
  .dig_ready (dig_ready),
  .dig       (dig)
);

### tb/tb_md5_digest_engine.sv
module tb_md5_digest_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  localparam logic [31:0] SINE_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                    6, 10, 15, 21};

  class md5_scoreboard;
    logic [31:0]   chain [4];
    logic [31:0]   blk [16];
    logic [63:0]   bits;
    md5_pkg::dig_t pending [$];
    int            errors;
    int            digests;
    int            messages;

    function new();
      foreach (blk[i]) blk[i] = '0;
      restart();
    endfunction

    function void restart();
      chain[0] = md5_pkg::INIT_A;
      chain[1] = md5_pkg::INIT_B;
      chain[2] = md5_pkg::INIT_C;
      chain[3] = md5_pkg::INIT_D;
      bits = '0;
    endfunction

    function void put_byte(int pos, logic [7:0] b);
      if (pos % 4 == 0) blk[pos / 4] = {24'h0, b};
      else blk[pos / 4] |= {24'h0, b} << (8 * (pos % 4));
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, s, nb;
      int widx, r;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        case (i / 16)
          0: begin
            f = (b & c) | (~b & d);
            widx = i;
          end
          1: begin
            f = (b & d) | (c & ~d);
            widx = (5 * i + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            widx = (3 * i + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            widx = (7 * i) % 16;
          end
        endcase
        s = a + f + blk[widx] + SINE_TAB[i];
        r = SHIFT_TAB[(i / 16) * 4 + i % 4];
        nb = b + ((s << r) | (s >> (32 - r)));
        a = d;
        d = c;
        c = b;
        b = nb;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void note_request(md5_pkg::msg_t m);
      int pos;
      md5_pkg::dig_t e;
      if (m.byte_present) begin
        pos = int'(bits[8:3]);
        put_byte(pos, m.data_byte);
        bits += 64'd8;
        if (pos == 63) compress();
      end
      if (!m.end_of_message) return;
      pos = int'(bits[8:3]);
      put_byte(pos, 8'h80);
      for (int k = pos + 1; k < 64; k++) put_byte(k, 8'h00);
      if (pos >= 56) begin
        compress();
        foreach (blk[i]) blk[i] = '0;
      end
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      compress();
      for (int k = 0; k < 4; k++) begin
        e.digest_word = chain[k];
        e.word_index = 2'(k);
        e.last_word = (k == 3);
        pending.push_back(e);
      end
      messages++;
      restart();
    endfunction

    function void check_digest(md5_pkg::dig_t got);
      md5_pkg::dig_t e;
      digests++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.digest_word !== e.digest_word) begin
        $display("%0t: digest_word exp %h got %h", $time, e.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== e.word_index) begin
        $display("%0t: word_index exp %0d got %0d", $time, e.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== e.last_word) begin
        $display("%0t: last_word exp %0d got %0d", $time, e.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_ready;
  md5_pkg::msg_t msg = '0;
  logic dig_valid;
  logic dig_ready = 1'b0;
  md5_pkg::dig_t dig;

  md5_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;

  md5_digest_engine dut (
    .clk(clk), .rst(rst), .msg_valid(msg_valid), .msg_ready(msg_ready), .msg(msg),
    .dig_valid(dig_valid), .dig_ready(dig_ready), .dig(dig)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[md5_digest_engine] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && dig_valid && dig_ready) sb.check_digest(dig);
    dig_ready <= ($urandom_range(99) >= recv_stall);
  end

  task send(input logic [7:0] b, input logic present, input logic eom);
    md5_pkg::msg_t m;
    m.data_byte = b;
    m.byte_present = present;
    m.end_of_message = eom;
    if ($urandom_range(99) < send_idle) begin
      msg_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= m;
    do @(posedge clk); while (!msg_ready);
    sb.note_request(m);
  endtask

  task send_message(input int len, input logic empty_terminator);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0);
      send(8'($urandom_range(255)), 1'b1, !empty_terminator && i == len - 1);
    end
    if (empty_terminator || len == 0) send(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task random_phase(input int items);
    int len;
    int sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: len = $urandom_range(12);
        5, 6: len = $urandom_range(64, 52);
        7: len = $urandom_range(40, 13);
        8: len = $urandom_range(130, 110);
        default: len = 0;
      endcase
      send_message(len, 1'($urandom_range(1)));
      sent += len + 1;
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Empty message, an idle request, then short messages with extreme bytes.
    send(8'hff, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'hff, 1'b1, 1'b0);
    send(8'h5a, 1'b1, 1'b1);
    send(8'ha5, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    send(8'hff, 1'b1, 1'b1);
    random_phase(45);
    send_idle = 81;
    random_phase(45);
    send_idle = 0;
    recv_stall = 81;
    random_phase(45);
    send_idle = 15;
    recv_stall = 15;
    random_phase(45);
    msg_valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    $display("Hashed %0d messages and checked %0d digest words in %0d cycles.",
             sb.messages, sb.digests, cycles);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[md5_digest_engine] OK");
    end else begin
      $display("%0d mismatches, %0d digest words missing", sb.errors, sb.pending.size());
      $display("[md5_digest_engine] ERROR");
    end
    $finish;
  end
endmodule

### md5_digest_engine.f
rtl/core/md5_pkg.sv
rtl/core/md5_ram.sv
rtl/core/md5_digest_engine.sv
rtl/core/md5_checker.sv
tb/tb_md5_digest_engine.sv
